// ===== rtl/core/pfgb_pkg.sv =====
// shared constants and action codes for the page framebuffer glyph blitter
`default_nettype none

package pfgb_pkg;

    localparam int DEF_SCREEN_WIDTH  = 128;
    localparam int DEF_SCREEN_HEIGHT = 64;
    localparam int DEF_GLYPH_COLUMNS = 5;
    localparam int DEF_GLYPH_ROWS    = 8;
    localparam int DEF_MAX_SCALE     = 8;

    localparam int ACTION_W  = 3;
    localparam int COORD_IN_W = 10;
    localparam int GLYPH_W   = 40;
    localparam int SCALE_W   = 4;
    localparam int INDEX_W   = 10;
    localparam int BYTE_W    = 8;

    // signed width of a working coordinate: origin plus glyph extent
    localparam int COORD_W   = 12;

    localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_RD_PIXEL = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_RD_BYTE  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_GLYPH    = 3'd4;

endpackage

`default_nettype wire

// ===== rtl/core/page_framebuffer_glyph_blitter.sv =====
// page-ordered monochrome framebuffer with pixel access, byte readout and glyph drawing
// byte read and pixel access read through the registered port; off-screen pixels skip it
// glyph: clear bits and clipped pixels are skipped; painted pixels are read, then written
// pixel and glyph writes are read-modify-writes through the one read and one write port
// after reset, busy stays high while the store is swept to zero
// done pulses for one cycle with read_value; a new word is taken in that same cycle
`default_nettype none

module page_framebuffer_glyph_blitter #(
    parameter int SCREEN_WIDTH  = pfgb_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = pfgb_pkg::DEF_SCREEN_HEIGHT,
    parameter int GLYPH_COLUMNS = pfgb_pkg::DEF_GLYPH_COLUMNS,
    parameter int GLYPH_ROWS    = pfgb_pkg::DEF_GLYPH_ROWS,
    parameter int MAX_SCALE     = pfgb_pkg::DEF_MAX_SCALE
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic [pfgb_pkg::ACTION_W-1:0]          action,
    input  wire logic signed [pfgb_pkg::COORD_IN_W-1:0] x_pos,
    input  wire logic signed [pfgb_pkg::COORD_IN_W-1:0] y_pos,
    input  wire logic                                   pixel_on,
    input  wire logic [pfgb_pkg::GLYPH_W-1:0]           glyph_bits,
    input  wire logic [pfgb_pkg::SCALE_W-1:0]           scale,
    input  wire logic [pfgb_pkg::INDEX_W-1:0]           byte_index,
    output logic                                        done,
    output logic [pfgb_pkg::BYTE_W-1:0]                 read_value
);
    import pfgb_pkg::*;

    localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
    localparam int FRAME_BYTES = SCREEN_WIDTH * PAGE_COUNT;
    localparam int AW          = $clog2(FRAME_BYTES);
    localparam int CW          = COORD_W;

    localparam logic [AW-1:0]          LAST_ADDR = AW'(FRAME_BYTES - 1);
    localparam logic [AW-1:0]          WIDTH_A   = AW'(SCREEN_WIDTH);
    localparam logic signed [CW-1:0]   WIDTH_S   = CW'(SCREEN_WIDTH);
    localparam logic signed [CW-1:0]   HEIGHT_S  = CW'(SCREEN_HEIGHT);
    localparam logic [2:0]             LAST_COL  = 3'(GLYPH_COLUMNS - 1);
    localparam logic [2:0]             LAST_ROW  = 3'(GLYPH_ROWS - 1);
    localparam logic [SCALE_W-1:0]     SCALE_CAP = SCALE_W'(MAX_SCALE);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PX_CHK,
        S_PX_WR,
        S_RD_WAIT
    } state_t;

    // control registers
    state_t              state_reg, state_next;
    logic [AW-1:0]       sweep_reg, sweep_next;
    logic                report_reg, report_next;
    logic                done_reg, done_next;
    logic [BYTE_W-1:0]   read_value_reg, read_value_next;

    // payload registers
    logic [ACTION_W-1:0]     act_reg, act_next;
    logic                    lit_reg, lit_next;
    logic [GLYPH_W-1:0]      glyph_reg, glyph_next;
    logic [SCALE_W-1:0]      s_reg, s_next;
    logic signed [CW-1:0]    oy_reg, oy_next;
    logic signed [CW-1:0]    bx_reg, bx_next;
    logic signed [CW-1:0]    by_reg, by_next;
    logic signed [CW-1:0]    cur_x_reg, cur_x_next;
    logic signed [CW-1:0]    cur_y_reg, cur_y_next;
    logic [SCALE_W-1:0]      dx_reg, dx_next;
    logic [SCALE_W-1:0]      dy_reg, dy_next;
    logic [2:0]              c_reg, c_next;
    logic [2:0]              r_reg, r_next;

    // memory port
    logic                mem_wr_en;
    logic [AW-1:0]       mem_wr_addr;
    logic [BYTE_W-1:0]   mem_wr_data;
    logic                mem_rd_en;
    logic [AW-1:0]       mem_rd_addr;
    logic [BYTE_W-1:0]   mem_rd_data;

    logic                on_screen;
    logic [AW-1:0]       pix_addr;
    logic [BYTE_W-1:0]   pix_mask;
    logic [63:0]         glyph_wide;
    logic                src_bit;
    logic signed [CW-1:0] s_ext;
    logic [SCALE_W-1:0]  s_in;
    logic                byte_in_range;
    logic                adv_skip;
    logic                adv_finish;

    pfgb_frame_mem #(
        .DEPTH (FRAME_BYTES),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign on_screen = !cur_x_reg[CW-1] && (cur_x_reg < WIDTH_S)
                    && !cur_y_reg[CW-1] && (cur_y_reg < HEIGHT_S);
    assign pix_addr  = AW'(cur_y_reg[CW-1:3]) * WIDTH_A + AW'(cur_x_reg[CW-1:0]);
    assign pix_mask  = 8'b1 << cur_y_reg[2:0];
    assign glyph_wide = {{(64 - GLYPH_W){1'b0}}, glyph_reg};
    assign src_bit   = glyph_wide[{c_reg, r_reg}];
    assign s_ext     = $signed({{(CW - SCALE_W){1'b0}}, s_reg});
    assign byte_in_range = 32'(byte_index) < 32'(FRAME_BYTES);

    // scale below one becomes one, above the cap saturates
    always_comb
    begin
        if (scale == '0)
        begin
            s_in = SCALE_W'(1);
        end
        else if (scale > SCALE_CAP)
        begin
            s_in = SCALE_CAP;
        end
        else
        begin
            s_in = scale;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        sweep_next      = sweep_reg;
        report_next     = report_reg;
        done_next       = 1'b0;
        read_value_next = read_value_reg;
        act_next        = act_reg;
        lit_next        = lit_reg;
        glyph_next      = glyph_reg;
        s_next          = s_reg;
        oy_next         = oy_reg;
        bx_next         = bx_reg;
        by_next         = by_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        c_next          = c_reg;
        r_next          = r_reg;

        mem_wr_en   = 1'b0;
        mem_wr_addr = pix_addr;
        mem_wr_data = lit_reg ? (mem_rd_data | pix_mask) : (mem_rd_data & ~pix_mask);
        mem_rd_en   = 1'b0;
        mem_rd_addr = pix_addr;

        adv_skip   = 1'b0;
        adv_finish = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = sweep_reg;
                mem_wr_data = '0;
                sweep_next  = sweep_reg + AW'(1);
                if (sweep_reg == LAST_ADDR)
                begin
                    state_next      = S_IDLE;
                    done_next       = report_reg;
                    read_value_next = '0;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    act_next   = action;
                    lit_next   = pixel_on;
                    glyph_next = glyph_bits;
                    s_next     = s_in;
                    cur_x_next = CW'(x_pos);
                    cur_y_next = CW'(y_pos);
                    bx_next    = CW'(x_pos);
                    by_next    = CW'(y_pos);
                    oy_next    = CW'(y_pos);
                    dx_next    = '0;
                    dy_next    = '0;
                    c_next     = '0;
                    r_next     = '0;
                    unique case (action) inside
                        ACT_CLEAR:
                        begin
                            state_next  = S_CLEAR;
                            sweep_next  = '0;
                            report_next = 1'b1;
                        end
                        ACT_WRITE, ACT_RD_PIXEL, ACT_GLYPH:
                        begin
                            state_next = S_PX_CHK;
                        end
                        ACT_RD_BYTE:
                        begin
                            if (byte_in_range)
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = AW'(byte_index);
                                state_next  = S_RD_WAIT;
                            end
                            else
                            begin
                                done_next       = 1'b1;
                                read_value_next = '0;
                            end
                        end
                        default:
                        begin
                            done_next       = 1'b1;
                            read_value_next = '0;
                        end
                    endcase
                end
            end

            S_PX_CHK:
            begin
                if (act_reg == ACT_GLYPH)
                begin
                    if (src_bit && on_screen)
                    begin
                        mem_rd_en  = 1'b1;
                        state_next = S_PX_WR;
                    end
                    else
                    begin
                        adv_skip = !src_bit;
                        adv_finish = 1'b1;
                    end
                end
                else if (on_screen)
                begin
                    mem_rd_en  = 1'b1;
                    state_next = (act_reg == ACT_RD_PIXEL) ? S_RD_WAIT : S_PX_WR;
                end
                else
                begin
                    state_next      = S_IDLE;
                    done_next       = 1'b1;
                    read_value_next = '0;
                end
            end

            S_PX_WR:
            begin
                mem_wr_en = 1'b1;
                if (act_reg == ACT_GLYPH)
                begin
                    adv_finish = 1'b1;
                end
                else
                begin
                    state_next      = S_IDLE;
                    done_next       = 1'b1;
                    read_value_next = '0;
                end
            end

            S_RD_WAIT:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                if (act_reg == ACT_RD_PIXEL)
                begin
                    read_value_next = {{(BYTE_W - 1){1'b0}}, mem_rd_data[cur_y_reg[2:0]]};
                end
                else
                begin
                    read_value_next = mem_rd_data;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // glyph walk: dx inner, then dy, then source row, then source column
        // a clear source bit jumps straight to the next source row
        if (adv_finish)
        begin
            if (!adv_skip && (dx_reg != s_reg - SCALE_W'(1)))
            begin
                dx_next    = dx_reg + SCALE_W'(1);
                cur_x_next = cur_x_reg + CW'(1);
                state_next = S_PX_CHK;
            end
            else if (!adv_skip && (dy_reg != s_reg - SCALE_W'(1)))
            begin
                dx_next    = '0;
                cur_x_next = bx_reg;
                dy_next    = dy_reg + SCALE_W'(1);
                cur_y_next = cur_y_reg + CW'(1);
                state_next = S_PX_CHK;
            end
            else if (r_reg != LAST_ROW)
            begin
                dx_next    = '0;
                dy_next    = '0;
                r_next     = r_reg + 3'd1;
                by_next    = by_reg + s_ext;
                cur_y_next = by_reg + s_ext;
                cur_x_next = bx_reg;
                state_next = S_PX_CHK;
            end
            else if (c_reg != LAST_COL)
            begin
                dx_next    = '0;
                dy_next    = '0;
                r_next     = '0;
                c_next     = c_reg + 3'd1;
                by_next    = oy_reg;
                cur_y_next = oy_reg;
                bx_next    = bx_reg + s_ext;
                cur_x_next = bx_reg + s_ext;
                state_next = S_PX_CHK;
            end
            else
            begin
                state_next      = S_IDLE;
                done_next       = 1'b1;
                read_value_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            sweep_reg      <= '0;
            report_reg     <= 1'b0;
            done_reg       <= 1'b0;
            read_value_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_reg      <= sweep_next;
            report_reg     <= report_next;
            done_reg       <= done_next;
            read_value_reg <= read_value_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        lit_reg   <= lit_next;
        glyph_reg <= glyph_next;
        s_reg     <= s_next;
        oy_reg    <= oy_next;
        bx_reg    <= bx_next;
        by_reg    <= by_next;
        cur_x_reg <= cur_x_next;
        cur_y_reg <= cur_y_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        c_reg     <= c_next;
        r_reg     <= r_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign read_value = read_value_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pfgb_frame_mem.sv =====
// frame byte store: one write port, one read port, registered read data
`default_nettype none

module pfgb_frame_mem #(
    parameter int DEPTH = pfgb_pkg::DEF_SCREEN_WIDTH * ((pfgb_pkg::DEF_SCREEN_HEIGHT + 7) / 8),
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                         clk,
    input  wire logic                         wr_en,
    input  wire logic [AW-1:0]                wr_addr,
    input  wire logic [pfgb_pkg::BYTE_W-1:0]  wr_data,
    input  wire logic                         rd_en,
    input  wire logic [AW-1:0]                rd_addr,
    output logic      [pfgb_pkg::BYTE_W-1:0]  rd_data
);
    import pfgb_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
